// File: hw/rtl/linear_extension_unrank_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear extension unranking block
// Concurrent property shorthands that compile to nothing under NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef LINEAR_EXTENSION_UNRANK_MACROS_SVH
`define LINEAR_EXTENSION_UNRANK_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define LEU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LEU_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define LEU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define LEU_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: hw/rtl/leu_pkg.sv
// ----------------------------------------------------------------------------
// Linear extension unranking package
// Shared constants, word layouts and command codes.
// ----------------------------------------------------------------------------
package leu_pkg;

	// Default sizing of the tables and of the walk.
	localparam int MAX_NODES_DEF  = 4096;
	localparam int MAX_SLOTS_DEF  = 16;
	localparam int MAX_LENGTH_DEF = 32;
	localparam int COUNT_BITS_DEF = 48;

	// Field widths of the input word.
	localparam int NODE_W   = 12;
	localparam int SLOT_W   = 4;
	localparam int TARGET_W = 12;
	localparam int LABEL_W  = 16;
	localparam int FCOUNT_W = 48;
	localparam int CMD_W    = 2;

	// Input tdata layout, lowest field first.
	localparam int NODE_LO   = 0;
	localparam int SLOT_LO   = NODE_LO + NODE_W;
	localparam int TARGET_LO = SLOT_LO + SLOT_W;
	localparam int TVALID_LO = TARGET_LO + TARGET_W;
	localparam int ELABEL_LO = TVALID_LO + 1;
	localparam int PCOUNT_LO = ELABEL_LO + LABEL_W;
	localparam int RANK_LO   = PCOUNT_LO + FCOUNT_W;
	localparam int IN_BITS   = RANK_LO + FCOUNT_W;
	localparam int S_DATA_W  = ((IN_BITS + 7) / 8) * 8;

	// Output word layout.
	localparam int POS_W    = 5;
	localparam int OUT_BITS = POS_W + LABEL_W;
	localparam int M_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Edge table entry: label, target, valid mark.
	localparam int EDGE_W = LABEL_W + TARGET_W + 1;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;
	localparam int NSLOTS_W   = 5;
	localparam int PLEN_W     = 6;
	localparam logic [NSLOTS_W-1:0] NSLOTS_RST = NSLOTS_W'(16);
	localparam logic [PLEN_W-1:0]   PLEN_RST   = PLEN_W'(32);

	localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_SLOTS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATH_LENGTH    = 1'b1;

	// Commands carried on tuser.
	localparam logic [CMD_W-1:0] CMD_WR_EDGE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WR_COUNT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd2;

endpackage

// File: hw/rtl/linear_extension_unrank.sv
// ----------------------------------------------------------------------------
// Linear extension unranking engine
// Holds an edge table and a node count table, and turns a rank into the
// sequence of edge labels on the walk from node 0 that the rank selects.
// ----------------------------------------------------------------------------
//
// Channel | Direction | Signals                          | Carries
// --------+-----------+----------------------------------+----------------------------
// s_      | in        | s_tvalid s_tready s_tdata s_tuser| table writes and queries
// m_      | out       | m_tvalid m_tready m_tdata m_tlast| labels, one word per position
//         |           | m_tuser                          |
// cfg_    | in        | cfg_we cfg_index cfg_data        | neighbor_slots, path_length
//
// For every step of a query, each slot up to and including the one that
// matched (or the last slot looked at) is read through the edge memory and
// then the count memory and compared, and the word is then handed over.
// Reset is asynchronous and clears only control state; the tables are
// undefined until written. Input is taken only between queries; a full
// output register holds the walk in its hand-over state.
//
module linear_extension_unrank #(
	parameter int MAX_NODES  = leu_pkg::MAX_NODES_DEF,
	parameter int MAX_SLOTS  = leu_pkg::MAX_SLOTS_DEF,
	parameter int MAX_LENGTH = leu_pkg::MAX_LENGTH_DEF,
	parameter int COUNT_BITS = leu_pkg::COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                              s_tvalid,
	output logic                              s_tready,
	// node, slot, target, target_valid, edge_label, path_count, rank, zero pad
	input  logic [leu_pkg::S_DATA_W-1:0]      s_tdata,
	// cmd
	input  logic [leu_pkg::CMD_W-1:0]         s_tuser,

	output logic                              m_tvalid,
	input  logic                              m_tready,
	// position, label, zero pad
	output logic [leu_pkg::M_DATA_W-1:0]      m_tdata,
	output logic                              m_tlast,
	// error
	output logic                              m_tuser,

	input  logic                              cfg_we,
	input  logic [leu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [leu_pkg::CFG_DATA_W-1:0]    cfg_data
);

`include "linear_extension_unrank_macros.svh"

	// Derived widths. A single slot still gets one index bit.
	localparam int NW = $clog2(MAX_NODES);
	localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int LW = $clog2(MAX_LENGTH + 1);
	localparam int CW = COUNT_BITS;
	localparam int EDGE_DEPTH = MAX_NODES * (1 << SW);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} leu_state_t;

	leu_state_t state_q;

	// Configuration registers.
	logic [leu_pkg::NSLOTS_W-1:0] nslots_q;
	logic [leu_pkg::PLEN_W-1:0]   plen_q;

	// Walk registers.
	logic [NW-1:0] cur_q;
	logic [CW-1:0] rank_q;
	logic [LW-1:0] step_q;
	logic [CW-1:0] start_q;
	logic [SW:0]   iss_q;

	// Unpacked input fields.
	logic [leu_pkg::NODE_W-1:0]   in_node;
	logic [leu_pkg::SLOT_W-1:0]   in_slot;
	logic [leu_pkg::TARGET_W-1:0] in_target;
	logic                         in_tvalid;
	logic [leu_pkg::LABEL_W-1:0]  in_label;
	logic [leu_pkg::FCOUNT_W-1:0] in_count;
	logic [leu_pkg::FCOUNT_W-1:0] in_rank;

	assign in_node   = s_tdata[leu_pkg::NODE_LO   +: leu_pkg::NODE_W];
	assign in_slot   = s_tdata[leu_pkg::SLOT_LO   +: leu_pkg::SLOT_W];
	assign in_target = s_tdata[leu_pkg::TARGET_LO +: leu_pkg::TARGET_W];
	assign in_tvalid = s_tdata[leu_pkg::TVALID_LO];
	assign in_label  = s_tdata[leu_pkg::ELABEL_LO +: leu_pkg::LABEL_W];
	assign in_count  = s_tdata[leu_pkg::PCOUNT_LO +: leu_pkg::FCOUNT_W];
	assign in_rank   = s_tdata[leu_pkg::RANK_LO   +: leu_pkg::FCOUNT_W];

	// Input words are taken only between queries.
	logic in_acc;
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// Range checks and index extraction for writes. Counts and ranks are
	// widened to 64 bits so that any COUNT_BITS picks its low bits cleanly.
	logic [31:0] node32, slot32;
	logic [63:0] count64, rank64;
	logic        node_ok, slot_ok;
	assign node32  = 32'(in_node);
	assign slot32  = 32'(in_slot);
	assign count64 = 64'(in_count);
	assign rank64  = 64'(in_rank);
	assign node_ok = node32 < 32'(MAX_NODES);
	assign slot_ok = slot32 < 32'(MAX_SLOTS);

	logic edge_we, cnt_we;
	assign edge_we = in_acc && (s_tuser == leu_pkg::CMD_WR_EDGE) && node_ok && slot_ok;
	assign cnt_we  = in_acc && (s_tuser == leu_pkg::CMD_WR_COUNT) && node_ok;

	// Effective configuration: saturate to the table sizes, a zero length
	// behaves as one.
	logic [SW:0]   slots_eff;
	logic [LW-1:0] len_eff;
	logic [31:0]   ns32, pl32;
	assign ns32      = 32'(nslots_q);
	assign pl32      = 32'(plen_q);
	assign slots_eff = (ns32 > 32'(MAX_SLOTS)) ? (SW+1)'(MAX_SLOTS) : (SW+1)'(nslots_q);
	assign len_eff   = (pl32 > 32'(MAX_LENGTH)) ? LW'(MAX_LENGTH) :
	                   (pl32 == 32'd0) ? LW'(1) : LW'(plen_q);

	// ------------------------------------------------------------------
	// Scan pipeline: issue (edge read) -> s1 (count read) -> s2 (compare).
	// Reads beyond the matching slot are speculative and simply dropped.
	// Writes only happen in the idle state, so a read never meets a write
	// to the same entry and no forwarding is needed.
	// ------------------------------------------------------------------
	logic in_scan, issue;
	logic dec_ok, dec_fail, decide;
	assign in_scan = (state_q == ST_SCAN);
	assign issue   = in_scan && (iss_q < slots_eff) && !decide;

	logic [leu_pkg::EDGE_W-1:0] edge_mem [EDGE_DEPTH];
	logic [CW-1:0]              cnt_mem  [MAX_NODES];

	logic [NW+SW-1:0]           edge_waddr, edge_raddr;
	logic [leu_pkg::EDGE_W-1:0] edge_wdata, edge_rd_s1;
	logic [NW-1:0]              cnt_waddr, cnt_raddr;
	logic [CW-1:0]              cnt_rd_s2;

	assign edge_waddr = {node32[NW-1:0], slot32[SW-1:0]};
	assign edge_wdata = {in_tvalid, in_target, in_label};
	assign edge_raddr = {cur_q, iss_q[SW-1:0]};
	assign cnt_waddr  = node32[NW-1:0];

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_waddr] <= edge_wdata;
		end
		edge_rd_s1 <= edge_mem[edge_raddr];
	end

	// Stage 1 fields from the edge word.
	logic [leu_pkg::LABEL_W-1:0]  lab_s1;
	logic [leu_pkg::TARGET_W-1:0] tgt_s1;
	logic                         evld_s1;
	logic [31:0]                  tgt32_s1;
	logic                         use_nxt;
	assign lab_s1   = edge_rd_s1[0 +: leu_pkg::LABEL_W];
	assign tgt_s1   = edge_rd_s1[leu_pkg::LABEL_W +: leu_pkg::TARGET_W];
	assign evld_s1  = edge_rd_s1[leu_pkg::EDGE_W-1];
	assign tgt32_s1 = 32'(tgt_s1);
	// A target outside the count table owns no interval.
	assign use_nxt  = evld_s1 && (tgt32_s1 < 32'(MAX_NODES));
	assign cnt_raddr = tgt32_s1[NW-1:0];

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= count64[CW-1:0];
		end
		cnt_rd_s2 <= cnt_mem[cnt_raddr];
	end

	// Pipeline valids and slot-end marks.
	logic v_s1, last_s1, v_s2, last_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v_s1    <= issue;
			last_s1 <= ((iss_q + (SW+1)'(1)) == slots_eff);
			v_s2    <= v_s1 && in_scan && !decide;
			last_s2 <= last_s1;
		end
	end

	// Stage 2 payload.
	logic                        use_s2;
	logic [NW-1:0]               tgt_s2;
	logic [leu_pkg::LABEL_W-1:0] lab_s2;
	always_ff @(posedge clk) begin
		use_s2 <= use_nxt;
		tgt_s2 <= tgt32_s1[NW-1:0];
		lab_s2 <= lab_s1;
	end

	// Interval test. The neighbour owns [start, start + count); a zero count
	// is skipped, and a running start that leaves the count range ends the
	// scan of this node.
	logic [CW:0] diff, sum;
	logic        live, hit, ovf, miss_end;
	assign live     = v_s2 && use_s2 && (cnt_rd_s2 != '0);
	assign diff     = {1'b0, rank_q} - {1'b0, start_q};
	assign sum      = {1'b0, start_q} + {1'b0, cnt_rd_s2};
	assign hit      = live && !diff[CW] && (diff[CW-1:0] < cnt_rd_s2);
	assign ovf      = live && !hit && sum[CW];
	assign miss_end = v_s2 && !hit && last_s2;

	// A hit on an edge labelled zero counts as a failure.
	assign dec_ok   = in_scan && hit && (lab_s2 != '0);
	assign dec_fail = in_scan && ((slots_eff == '0) || ovf || miss_end ||
	                              (hit && (lab_s2 == '0)));
	assign decide   = dec_ok || dec_fail;

	// Result held between the decision and the hand-over.
	logic [leu_pkg::POS_W-1:0]   res_pos_q;
	logic [leu_pkg::LABEL_W-1:0] res_lab_q;
	logic                        res_last_q, res_err_q;
	logic [31:0]                 pos32;
	assign pos32 = 32'(step_q) - 32'd1;

	always_ff @(posedge clk) begin
		if (decide) begin
			res_pos_q  <= pos32[leu_pkg::POS_W-1:0];
			res_lab_q  <= dec_ok ? lab_s2 : '0;
			res_err_q  <= dec_fail;
			res_last_q <= dec_fail || (step_q == LW'(1));
		end
	end

	// Output register.
	logic                        m_valid_q, m_last_q, m_err_q;
	logic [leu_pkg::POS_W-1:0]   m_pos_q;
	logic [leu_pkg::LABEL_W-1:0] m_lab_q;
	logic                        out_free, out_load;
	assign out_free = !m_valid_q || m_tready;
	assign out_load = (state_q == ST_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_pos_q  <= res_pos_q;
			m_lab_q  <= res_lab_q;
			m_last_q <= res_last_q;
			m_err_q  <= res_err_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = leu_pkg::M_DATA_W'({m_lab_q, m_pos_q});
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_err_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nslots_q <= leu_pkg::NSLOTS_RST;
			plen_q   <= leu_pkg::PLEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				leu_pkg::CFG_NEIGHBOR_SLOTS: nslots_q <= cfg_data[leu_pkg::NSLOTS_W-1:0];
				leu_pkg::CFG_PATH_LENGTH:    plen_q   <= cfg_data[leu_pkg::PLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Walk control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q   <= '0;
			rank_q  <= '0;
			step_q  <= '0;
			start_q <= '0;
			iss_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (s_tuser == leu_pkg::CMD_QUERY)) begin
						cur_q   <= '0;
						rank_q  <= rank64[CW-1:0];
						step_q  <= len_eff;
						start_q <= '0;
						iss_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						iss_q <= iss_q + (SW+1)'(1);
					end
					if (live && !hit && !ovf) begin
						start_q <= sum[CW-1:0];
					end
					if (decide) begin
						if (dec_ok) begin
							cur_q  <= tgt_s2;
							rank_q <= diff[CW-1:0];
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (res_last_q) begin
							state_q <= ST_IDLE;
						end else begin
							step_q  <= step_q - LW'(1);
							start_q <= '0;
							iss_q   <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The compare stage only ever carries a slot while a node is scanned.
	`LEU_ASSERT_IMP(a_s2_in_scan, clk, arst_n, v_s2, state_q == ST_SCAN,
		"compare stage valid outside the scan")

	// An accepted query starts a scan with at least one step to go.
	`LEU_ASSERT_NXT(a_query_starts, clk, arst_n,
		in_acc && (s_tuser == leu_pkg::CMD_QUERY),
		(state_q == ST_SCAN) && (step_q != '0), "query did not start a scan")

	// While a query runs there is always a position left to fill.
	`LEU_ASSERT_IMP(a_step_live, clk, arst_n, state_q != ST_IDLE, step_q != '0,
		"walk running with no step left")

	// An error word always closes the query.
	`LEU_ASSERT_IMP(a_err_last, clk, arst_n, m_tvalid && m_tuser, m_tlast,
		"error word not marked last")

	// The slot issue counter never runs past the slots in use.
	`LEU_ASSERT_IMP(a_iss_bound, clk, arst_n, state_q == ST_SCAN, iss_q <= slots_eff,
		"slot issue counter beyond the slot count")

endmodule
